@@ rtl/lpbw_pkg.sv @@
// Shared types, codes and lane helpers for the LCD parallel-bus word packer.
// Used by every module of the block; depends on nothing else.
package lpbw_pkg;

  localparam int LaneBytes = 8;   // longest byte stream: four command and four data bytes
  localparam int Words     = 4;   // port words per item at most

  // Request codes
  localparam logic [2:0] CMD_WR_CMD  = 3'd0;
  localparam logic [2:0] CMD_WR_DATA = 3'd1;
  localparam logic [2:0] CMD_WR_BOTH = 3'd2;
  localparam logic [2:0] CMD_SET_CS  = 3'd3;
  localparam logic [2:0] CMD_IMG     = 3'd4;
  localparam logic [2:0] CMD_REG     = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_EN  = 2'd1;
  localparam logic [1:0] ST_CS_LOW  = 2'd2;
  localparam logic [1:0] ST_BAD_WID = 2'd3;

  // Configuration register indexes
  localparam logic CFG_IF_ENABLE = 1'b0;
  localparam logic CFG_FORCED_CS = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] cmd_value;
    logic [5:0]  cmd_width;
    logic [31:0] data_value;
    logic [5:0]  data_width;
    logic        cs_enable;
  } req_t;

  typedef struct packed {
    logic [31:0] port_word;
    logic        word_present;
    logic [1:0]  status;
    logic        chip_select;
    logic        image_path;
    logic        last;
  } rsp_t;

  // Everything one request produces, held while its results go out
  typedef struct packed {
    logic [Words-1:0][31:0] words;
    logic [2:0]             word_count;
    logic [1:0]             tail_status;  // status of the trailing result without a word
    logic                   cs_next;
    logic                   path_next;
    logic [1:0]             last_idx;
  } burst_t;

  function automatic logic width_ok(input logic [5:0] w);
    return (w == 6'd8) || (w == 6'd16) || (w == 6'd24) || (w == 6'd32);
  endfunction

  // One lane: byte at 0-7, valid at 8, data/command flag at 15
  function automatic logic [15:0] lane_bits(input logic [7:0] b, input logic dc);
    return {dc, 6'b0, 1'b1, b};
  endfunction

endpackage

@@ rtl/lcd_parallel_bus_word_packer_core.sv @@
// Top level of the LCD parallel-bus word packer: request register, config, state.
// Depends on lpbw_pkg, lpbw_pack and lpbw_emit.
//
//   channel   | handshake          | payload
//   ----------+--------------------+----------------------------------
//   request   | req_valid/req_stall| req  (lpbw_pkg::req_t)
//   result    | rsp_valid/rsp_stall| rsp  (lpbw_pkg::rsp_t)
//   config    | cfg_we             | cfg_index, cfg_wdata
//
// A request is held in the request register, is packed on the way into the result
// register, and then shows one result per cycle unless the result port stalls: 1 to 4
// results per request. Requests that give one result go through one a cycle when no stall.
// Reset clears the config registers, chip select level and image path select.
// A stalled result holds; the request register keeps accepting while the result
// register drains its last result.
module lcd_parallel_bus_word_packer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lpbw_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lpbw_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_wdata
);

  logic             if_enable;
  logic             forced_cs;
  logic             cs_level;
  logic             path_is_image;
  logic             hold_valid;
  lpbw_pkg::req_t   hold;
  lpbw_pkg::burst_t burst;
  logic             free;
  logic             load;

  always_ff @(posedge clk) begin
    if (rst) begin
      if_enable <= 1'b0;
      forced_cs <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpbw_pkg::CFG_IF_ENABLE: if_enable <= cfg_wdata;
        lpbw_pkg::CFG_FORCED_CS: forced_cs <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign load      = hold_valid && free;
  assign req_stall = hold_valid && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
  end

  // state advances as the item enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_level      <= 1'b0;
      path_is_image <= 1'b0;
    end else if (load) begin
      cs_level      <= burst.cs_next;
      path_is_image <= burst.path_next;
    end
  end

  lpbw_pack u_pack (
    .req           (hold),
    .if_enable     (if_enable),
    .forced_cs     (forced_cs),
    .cs_level      (cs_level),
    .path_is_image (path_is_image),
    .burst         (burst)
  );

  lpbw_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst_in  (burst),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ rtl/lpbw_pack.sv @@
// Request checker and byte-stream packer: one request in, all its port words out.
// Pure logic; depends on lpbw_pkg.
module lpbw_pack (
  input  lpbw_pkg::req_t   req,
  input  logic             if_enable,
  input  logic             forced_cs,
  input  logic             cs_level,
  input  logic             path_is_image,
  output lpbw_pkg::burst_t burst
);

  logic [2:0]  n_cmd;
  logic [2:0]  n_data;
  logic        flush;
  logic        err;
  logic [1:0]  err_status;
  logic        cs_next;
  logic        path_next;
  logic [3:0]  len;
  logic [2:0]  pairs;
  logic [2:0]  word_count;
  logic        tail;
  logic [2:0]  total;
  logic [7:0]  sbyte [lpbw_pkg::LaneBytes];
  logic        sdc   [lpbw_pkg::LaneBytes];
  logic [1:0]  dpos  [lpbw_pkg::LaneBytes];
  logic [lpbw_pkg::Words-1:0][31:0] words;

  always_comb begin
    n_cmd      = 3'd0;
    n_data     = 3'd0;
    flush      = 1'b1;
    err        = 1'b0;
    err_status = lpbw_pkg::ST_OK;
    cs_next    = cs_level;
    path_next  = path_is_image;
    case (req.command) inside
      lpbw_pkg::CMD_WR_CMD, lpbw_pkg::CMD_WR_DATA, lpbw_pkg::CMD_WR_BOTH: begin
        if (!if_enable) begin
          err        = 1'b1;
          err_status = lpbw_pkg::ST_NOT_EN;
        end else if (forced_cs && !cs_level) begin
          err        = 1'b1;
          err_status = lpbw_pkg::ST_CS_LOW;
        end else begin
          path_next = 1'b0;
          if (req.command == lpbw_pkg::CMD_WR_DATA) begin
            if (!lpbw_pkg::width_ok(req.data_width)) begin
              err        = 1'b1;
              err_status = lpbw_pkg::ST_BAD_WID;
            end else begin
              n_data = req.data_width[5:3];
            end
          end else if (!lpbw_pkg::width_ok(req.cmd_width)) begin
            err        = 1'b1;
            err_status = lpbw_pkg::ST_BAD_WID;
          end else begin
            n_cmd = req.cmd_width[5:3];
            if (req.command == lpbw_pkg::CMD_WR_BOTH) begin
              if (lpbw_pkg::width_ok(req.data_width)) begin
                n_data = req.data_width[5:3];
              end else begin
                // send whole command pairs, drop an odd command byte
                flush      = 1'b0;
                err        = 1'b1;
                err_status = lpbw_pkg::ST_BAD_WID;
              end
            end
          end
        end
      end
      lpbw_pkg::CMD_SET_CS: begin
        if (!if_enable || !forced_cs) begin
          err        = 1'b1;
          err_status = lpbw_pkg::ST_NOT_EN;
        end else begin
          cs_next = req.cs_enable;
        end
      end
      lpbw_pkg::CMD_IMG, lpbw_pkg::CMD_REG: begin
        if (!if_enable) begin
          err        = 1'b1;
          err_status = lpbw_pkg::ST_NOT_EN;
        end else begin
          path_next = (req.command == lpbw_pkg::CMD_IMG);
        end
      end
      default: begin
      end
    endcase
  end

  // Command bytes first, then data bytes, least significant first
  always_comb begin
    for (int p = 0; p < lpbw_pkg::LaneBytes; p++) begin
      dpos[p] = 2'(3'(p) - n_cmd);
      if (3'(p) < n_cmd) begin
        sbyte[p] = req.cmd_value[8*(p & 3) +: 8];
        sdc[p]   = 1'b0;
      end else begin
        sbyte[p] = req.data_value[8*dpos[p] +: 8];
        sdc[p]   = 1'b1;
      end
    end
  end

  assign len        = {1'b0, n_cmd} + {1'b0, n_data};
  assign pairs      = len[3:1];
  assign word_count = pairs + {2'b0, flush & len[0]};

  always_comb begin
    for (int i = 0; i < lpbw_pkg::Words; i++) begin
      if (3'(i) < pairs) begin
        words[i] = {lpbw_pkg::lane_bits(sbyte[2*i+1], sdc[2*i+1]),
                    lpbw_pkg::lane_bits(sbyte[2*i], sdc[2*i])};
      end else if ((3'(i) == pairs) && flush && len[0]) begin
        words[i] = {16'h0, lpbw_pkg::lane_bits(sbyte[2*i], sdc[2*i])};
      end else begin
        words[i] = 32'h0;
      end
    end
  end

  assign tail  = err || (word_count == 3'd0);
  assign total = word_count + {2'b0, tail};

  assign burst.words       = words;
  assign burst.word_count  = word_count;
  assign burst.tail_status = err_status;
  assign burst.cs_next     = cs_next;
  assign burst.path_next   = path_next;
  assign burst.last_idx    = 2'(total - 3'd1);

endmodule

@@ rtl/lpbw_emit.sv @@
// Result register: holds one request's words and steps out one result per take.
// Depends on lpbw_pkg.
module lpbw_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lpbw_pkg::burst_t burst_in,
  output logic             free,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output lpbw_pkg::rsp_t   rsp
);

  logic             busy;
  logic [1:0]       idx;
  lpbw_pkg::burst_t bank;
  logic             take;
  logic             is_word;
  logic             is_last;

  assign is_word = ({1'b0, idx} < bank.word_count);
  assign is_last = (idx == bank.last_idx);
  assign take    = busy && !rsp_stall;
  assign free    = !busy || (take && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take) begin
      if (is_last) begin
        busy <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank <= burst_in;
    end
  end

  assign rsp_valid        = busy;
  assign rsp.port_word    = is_word ? bank.words[idx] : 32'h0;
  assign rsp.word_present = is_word;
  assign rsp.status       = is_word ? lpbw_pkg::ST_OK : bank.tail_status;
  assign rsp.chip_select  = bank.cs_next;
  assign rsp.image_path   = bank.path_next;
  assign rsp.last         = is_last;

endmodule

@@ rtl/lpbw_checker.sv @@
// Port-level checks for the LCD parallel-bus word packer, bound to the top level.
// Depends on lpbw_pkg.
module lpbw_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input lpbw_pkg::rsp_t rsp
);

  // a word result never carries an error
  a_word_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.word_present |-> rsp.status == lpbw_pkg::ST_OK)
    else $error("word result with error status");

  // no word means a zero word
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.word_present |-> rsp.port_word == 32'h0)
    else $error("nonzero port word without word_present");

  // lane 0 is always filled when a word goes out
  a_lane0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.word_present |-> rsp.port_word[8])
    else $error("word without lane 0 valid");

  // a taken result that is not the last is followed by the next one at once
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp.last |=> rsp_valid)
    else $error("item results broken up");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind lcd_parallel_bus_word_packer_core lpbw_checker u_lpbw_checker (.*);
